// ----- hw/rtl/gfmds_pkg.sv -----
// gfmds_pkg: item types, field widths, matrices and gf(2^16) helpers for the
// mds round linear layer; self-contained, used by gf216_mds_round_linear_layer_core
package gfmds_pkg;

  localparam int WORD_W      = 16;
  localparam int WORDS       = 8;
  localparam int WIDX_W      = $clog2(WORDS);
  localparam int RIDX_W      = 3;
  localparam int RC_PAD      = WORD_W - RIDX_W - WIDX_W;
  localparam int ROUND_COUNT = 7;

  // low terms of x^16+x^5+x^3+x+1
  localparam logic [WORD_W-1:0] POLY_LOW = 16'h002B;

  localparam logic ACT_FWD = 1'b0;
  localparam logic ACT_INV = 1'b1;

  typedef struct packed {
    logic              action;
    logic [RIDX_W-1:0] round_index;
    logic [WORD_W-1:0] word_0;
    logic [WORD_W-1:0] word_1;
    logic [WORD_W-1:0] word_2;
    logic [WORD_W-1:0] word_3;
    logic [WORD_W-1:0] word_4;
    logic [WORD_W-1:0] word_5;
    logic [WORD_W-1:0] word_6;
    logic [WORD_W-1:0] word_7;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_0;
    logic [WORD_W-1:0] out_1;
    logic [WORD_W-1:0] out_2;
    logic [WORD_W-1:0] out_3;
    logic [WORD_W-1:0] out_4;
    logic [WORD_W-1:0] out_5;
    logic [WORD_W-1:0] out_6;
    logic [WORD_W-1:0] out_7;
  } out_item_t;

  localparam logic [WORD_W-1:0] FWD_MAT [WORDS][WORDS] = '{
    '{16'h1967, 16'h2BA9, 16'h659C, 16'h7CFB, 16'h5752, 16'hCB38, 16'hE091, 16'h4E35},
    '{16'hB1C3, 16'h6F41, 16'hD26E, 16'hBD2F, 16'h7A75, 16'h63AD, 16'h0CEC, 16'hCBB6},
    '{16'h64CE, 16'hFDE8, 16'h9926, 16'hAB41, 16'h62DD, 16'hCF8F, 16'h56A9, 16'hC99C},
    '{16'h40E8, 16'h00D7, 16'hC041, 16'h403F, 16'hC096, 16'hC1EF, 16'h01AE, 16'h80A9},
    '{16'hAC87, 16'h91DF, 16'h4789, 16'h1EAC, 16'hB22B, 16'hD656, 16'hC8FA, 16'h7AD1},
    '{16'hC9BC, 16'h56B1, 16'hCF93, 16'h62F1, 16'hAB4D, 16'h9922, 16'hFDFC, 16'h64DE},
    '{16'h1472, 16'h7D59, 16'hB480, 16'h4E32, 16'h2719, 16'hEEC0, 16'hC9D9, 16'h5A40},
    '{16'hD081, 16'h271E, 16'h5AF3, 16'hFBDA, 16'h8637, 16'hAD6C, 16'h7DED, 16'h2B5B}
  };

  localparam logic [WORD_W-1:0] INV_MAT [WORDS][WORDS] = '{
    '{16'h8644, 16'h738D, 16'h42A7, 16'h86B1, 16'h9477, 16'h07D8, 16'h9B6A, 16'hB308},
    '{16'h8AE7, 16'hD162, 16'h1204, 16'h077A, 16'h3086, 16'h021A, 16'hF967, 16'h19FC},
    '{16'h1946, 16'h9497, 16'h50A3, 16'h8276, 16'hFAA8, 16'h02E1, 16'hB113, 16'h3341},
    '{16'h9F02, 16'h45F5, 16'hF1E5, 16'h81CB, 16'hD26D, 16'h06D5, 16'h43F6, 16'h557A},
    '{16'h15E5, 16'h8BEA, 16'h74AB, 16'h850C, 16'h461A, 16'h010D, 16'h21FB, 16'h7FC7},
    '{16'h328C, 16'hE71A, 16'hB342, 16'h8C82, 16'hCA2E, 16'h00FB, 16'h698F, 16'h99B5},
    '{16'hB86B, 16'h3678, 16'hE3E1, 16'h0EF4, 16'h1843, 16'h0317, 16'h4874, 16'h2ABD},
    '{16'h93A1, 16'hF867, 16'h854E, 16'h04C7, 16'h5E59, 16'h03EC, 16'hD89C, 16'hE672}
  };

  // used with a constant first operand, so it folds into an xor tree
  function automatic logic [WORD_W-1:0] gf_mul(input logic [WORD_W-1:0] k,
                                               input logic [WORD_W-1:0] a);
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] p;
    acc = '0;
    p   = a;
    for (int i = 0; i < WORD_W; i++) begin
      if (k[i]) begin
        acc = acc ^ p;
      end
      p = {p[WORD_W-2:0], 1'b0} ^ (p[WORD_W-1] ? POLY_LOW : '0);
    end
    return acc;
  endfunction

endpackage

// ----- hw/rtl/gf216_mds_round_linear_layer_core.sv -----
// gf216_mds_round_linear_layer_core: 8x8 mds mix over gf(2^16) with round constants
// depends on gfmds_pkg for item types, matrices and the field multiply
//
//   channel | direction | payload              | handshake
//   --------+-----------+----------------------+-------------------
//   in_     | input     | gfmds_pkg::in_item_t  | in_valid / in_stall
//   out_    | output    | gfmds_pkg::out_item_t | out_valid / out_stall
//
// one item per cycle sustained while out_stall is low; an accepted item reaches out_valid through
// the input register, the xor-tree matrix logic and the result register
// rst_n is synchronous and clears both valid flags; payload registers are not reset
// a stalled result holds; the input register still takes one more item behind it,
// so in_stall rises only when both registers are full and out_stall is high
module gf216_mds_round_linear_layer_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gfmds_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gfmds_pkg::out_item_t out_item
);

  logic                 s1_valid_r;
  gfmds_pkg::in_item_t  s1_item_r;
  logic                 out_valid_r;
  gfmds_pkg::out_item_t out_item_r;
  gfmds_pkg::out_item_t out_item_nxt;

  logic out_en;
  logic s1_en;

  logic [gfmds_pkg::RIDX_W-1:0] ridx_sat;
  logic [gfmds_pkg::WORD_W-1:0] w   [gfmds_pkg::WORDS];
  logic [gfmds_pkg::WORD_W-1:0] rc  [gfmds_pkg::WORDS];
  logic [gfmds_pkg::WORD_W-1:0] v   [gfmds_pkg::WORDS];
  logic [gfmds_pkg::WORD_W-1:0] yf  [gfmds_pkg::WORDS];
  logic [gfmds_pkg::WORD_W-1:0] yi  [gfmds_pkg::WORDS];
  logic [gfmds_pkg::WORD_W-1:0] y   [gfmds_pkg::WORDS];

  assign out_en   = !out_valid_r || !out_stall;
  assign s1_en    = !s1_valid_r || out_en;
  assign in_stall = !s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  always_comb begin
    // rounds past the last one use the last round's constants
    if (int'(s1_item_r.round_index) >= gfmds_pkg::ROUND_COUNT) begin
      ridx_sat = gfmds_pkg::RIDX_W'(gfmds_pkg::ROUND_COUNT - 1);
    end else begin
      ridx_sat = s1_item_r.round_index;
    end

    w[0] = s1_item_r.word_0;
    w[1] = s1_item_r.word_1;
    w[2] = s1_item_r.word_2;
    w[3] = s1_item_r.word_3;
    w[4] = s1_item_r.word_4;
    w[5] = s1_item_r.word_5;
    w[6] = s1_item_r.word_6;
    w[7] = s1_item_r.word_7;

    for (int k = 0; k < gfmds_pkg::WORDS; k++) begin
      // 8*r + k + 1
      rc[k] = {{gfmds_pkg::RC_PAD{1'b0}}, ridx_sat, gfmds_pkg::WIDX_W'(k)}
              + gfmds_pkg::WORD_W'(1);
      v[k]  = w[k] ^ rc[k];
    end

    for (int a = 0; a < gfmds_pkg::WORDS; a++) begin
      yf[a] = rc[a];
      yi[a] = '0;
      for (int b = 0; b < gfmds_pkg::WORDS; b++) begin
        yf[a] = yf[a] ^ gfmds_pkg::gf_mul(gfmds_pkg::FWD_MAT[a][b], w[b]);
        yi[a] = yi[a] ^ gfmds_pkg::gf_mul(gfmds_pkg::INV_MAT[a][b], v[b]);
      end
      y[a] = (s1_item_r.action == gfmds_pkg::ACT_INV) ? yi[a] : yf[a];
    end

    out_item_nxt.out_0 = y[0];
    out_item_nxt.out_1 = y[1];
    out_item_nxt.out_2 = y[2];
    out_item_nxt.out_3 = y[3];
    out_item_nxt.out_4 = y[4];
    out_item_nxt.out_5 = y[5];
    out_item_nxt.out_6 = y[6];
    out_item_nxt.out_7 = y[7];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while a register is free");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("accepted item lost before input register");

  a_s1_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_en) |=> out_valid_r)
    else $error("item in input register did not reach result register");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_en) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input register changed while blocked");

endmodule

// ----- dv/gf216_mds_round_linear_layer_core_tb.sv -----
`timescale 1ns / 100ps
// gf216_mds_round_linear_layer_core_tb: self-checking bench for the gf(2^16) mds round layer
// depends on gfmds_pkg for item types and action codes; own predictor, no external files
module gf216_mds_round_linear_layer_core_tb;

  localparam int          LIMIT_CYCLES = 100000;
  localparam int          RANDOM_ITEMS = 450;
  localparam int          ROUNDS       = 7;
  localparam int          MID_DRAIN    = 250;
  localparam logic [15:0] RED_POLY     = 16'h002B;

  localparam logic [15:0] FWD_COEF [8][8] = '{
    '{16'h1967, 16'h2BA9, 16'h659C, 16'h7CFB, 16'h5752, 16'hCB38, 16'hE091, 16'h4E35},
    '{16'hB1C3, 16'h6F41, 16'hD26E, 16'hBD2F, 16'h7A75, 16'h63AD, 16'h0CEC, 16'hCBB6},
    '{16'h64CE, 16'hFDE8, 16'h9926, 16'hAB41, 16'h62DD, 16'hCF8F, 16'h56A9, 16'hC99C},
    '{16'h40E8, 16'h00D7, 16'hC041, 16'h403F, 16'hC096, 16'hC1EF, 16'h01AE, 16'h80A9},
    '{16'hAC87, 16'h91DF, 16'h4789, 16'h1EAC, 16'hB22B, 16'hD656, 16'hC8FA, 16'h7AD1},
    '{16'hC9BC, 16'h56B1, 16'hCF93, 16'h62F1, 16'hAB4D, 16'h9922, 16'hFDFC, 16'h64DE},
    '{16'h1472, 16'h7D59, 16'hB480, 16'h4E32, 16'h2719, 16'hEEC0, 16'hC9D9, 16'h5A40},
    '{16'hD081, 16'h271E, 16'h5AF3, 16'hFBDA, 16'h8637, 16'hAD6C, 16'h7DED, 16'h2B5B}
  };

  localparam logic [15:0] INV_COEF [8][8] = '{
    '{16'h8644, 16'h738D, 16'h42A7, 16'h86B1, 16'h9477, 16'h07D8, 16'h9B6A, 16'hB308},
    '{16'h8AE7, 16'hD162, 16'h1204, 16'h077A, 16'h3086, 16'h021A, 16'hF967, 16'h19FC},
    '{16'h1946, 16'h9497, 16'h50A3, 16'h8276, 16'hFAA8, 16'h02E1, 16'hB113, 16'h3341},
    '{16'h9F02, 16'h45F5, 16'hF1E5, 16'h81CB, 16'hD26D, 16'h06D5, 16'h43F6, 16'h557A},
    '{16'h15E5, 16'h8BEA, 16'h74AB, 16'h850C, 16'h461A, 16'h010D, 16'h21FB, 16'h7FC7},
    '{16'h328C, 16'hE71A, 16'hB342, 16'h8C82, 16'hCA2E, 16'h00FB, 16'h698F, 16'h99B5},
    '{16'hB86B, 16'h3678, 16'hE3E1, 16'h0EF4, 16'h1843, 16'h0317, 16'h4874, 16'h2ABD},
    '{16'h93A1, 16'hF867, 16'h854E, 16'h04C7, 16'h5E59, 16'h03EC, 16'hD89C, 16'hE672}
  };

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  gfmds_pkg::in_item_t  in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  gfmds_pkg::out_item_t out_item;

  gfmds_pkg::in_item_t  block_q [$];
  gfmds_pkg::out_item_t mixed_q [$];
  logic      in_taken    = 1'b0;
  int        n_directed  = 0;
  int        sent_cnt    = 0;
  int        burst_left  = 0;
  int        gap_left    = 0;
  int        mixed_seen  = 0;
  int        hold_left   = 0;
  bit        hold_done   = 0;
  int        rx_cyc      = 0;
  int        cyc         = 0;
  int        errors      = 0;

  gf216_mds_round_linear_layer_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #10 clk = ~clk;

  // horner form, msb of the multiplier first
  function automatic logic [15:0] gf_times(input logic [15:0] x, input logic [15:0] y);
    logic [15:0] acc;
    acc = '0;
    for (int i = 15; i >= 0; i--) begin
      acc = {acc[14:0], 1'b0} ^ (acc[15] ? RED_POLY : 16'h0000);
      if (y[i]) begin
        acc = acc ^ x;
      end
    end
    return acc;
  endfunction

  // word k sits at bits [(7-k)*16 +: 16] of the low 128 bits
  function automatic gfmds_pkg::out_item_t mix_block(input gfmds_pkg::in_item_t blk);
    logic [127:0] flat_in;
    logic [127:0] flat_out;
    logic [15:0]  v [8];
    logic [15:0]  s;
    int           r;
    bit           inv;
    inv     = (blk.action == gfmds_pkg::ACT_INV);
    r       = (int'(blk.round_index) >= ROUNDS) ? ROUNDS - 1 : int'(blk.round_index);
    flat_in = blk[127:0];
    for (int k = 0; k < 8; k++) begin
      v[k] = flat_in[(7-k)*16 +: 16];
      if (inv) begin
        v[k] = v[k] ^ 16'(8 * r + k + 1);
      end
    end
    for (int a = 0; a < 8; a++) begin
      s = '0;
      for (int b = 0; b < 8; b++) begin
        s = s ^ gf_times(inv ? INV_COEF[a][b] : FWD_COEF[a][b], v[b]);
      end
      if (!inv) begin
        s = s ^ 16'(8 * r + a + 1);
      end
      flat_out[(7-a)*16 +: 16] = s;
    end
    return gfmds_pkg::out_item_t'(flat_out);
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001 << $urandom_range(0, 15);
      3:       return ~(16'h0001 << $urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_block(input logic act, input logic [2:0] rnd, input logic [127:0] words);
    block_q.push_back(gfmds_pkg::in_item_t'({act, rnd, words}));
  endtask

  initial begin
    logic [127:0] words;
    queue_block(gfmds_pkg::ACT_FWD, 3'd0, '0);
    queue_block(gfmds_pkg::ACT_INV, 3'd0, '0);
    queue_block(gfmds_pkg::ACT_FWD, 3'd6, {8{16'hFFFF}});
    queue_block(gfmds_pkg::ACT_INV, 3'd6, {8{16'hFFFF}});
    queue_block(gfmds_pkg::ACT_FWD, 3'd2, {4{16'hAAAA, 16'h5555}});
    queue_block(gfmds_pkg::ACT_INV, 3'd5, {4{16'h5555, 16'hAAAA}});
    // rounds past the last one saturate; both directions at every index
    for (int r = 0; r < 8; r++) begin
      queue_block(r[0] ? gfmds_pkg::ACT_INV : gfmds_pkg::ACT_FWD, 3'(r),
                  {8{16'h0001 << (2 * r)}});
      queue_block(r[0] ? gfmds_pkg::ACT_FWD : gfmds_pkg::ACT_INV, 3'(r),
                  {8{16'h8000 >> r}});
    end
    n_directed = block_q.size();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      for (int k = 0; k < 8; k++) begin
        words[k*16 +: 16] = rand_word();
      end
      queue_block($urandom_range(0, 1) ? gfmds_pkg::ACT_INV : gfmds_pkg::ACT_FWD,
                  3'($urandom_range(0, 7)), words);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (block_q.size() != 0 || in_valid) @(negedge clk);
    while (mixed_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("gf216_mds_round_linear_layer_core verification clean");
    end else begin
      $display("gf216_mds_round_linear_layer_core verification failed");
    end
    $finish;
  end

  // acceptance and prediction at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      mixed_q.push_back(mix_block(in_item));
    end
  end

  // sender: bursts and gaps, with a full drain after the directed items and mid-run
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (block_q.size() == 0 ||
                   ((sent_cnt == n_directed || sent_cnt == MID_DRAIN) && mixed_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_item  <= block_q.pop_front();
        in_valid <= 1'b1;
        sent_cnt++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 32);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: one long hold-off, otherwise stall style changes every 50 results
  always @(negedge clk) begin
    rx_cyc++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && mixed_seen >= 120) begin
      hold_done = 1;
      hold_left = 80;
      out_stall <= 1'b1;
    end else begin
      case ((mixed_seen / 50) % 4)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (rx_cyc % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    gfmds_pkg::out_item_t want;
    logic [127:0]         w_flat;
    logic [127:0]         g_flat;
    if (rst_n && out_valid && !out_stall) begin
      mixed_seen++;
      if (mixed_q.size() == 0) begin
        $display("%0t unexpected item: expected none, actual %h", $time, out_item);
        errors++;
      end else begin
        want   = mixed_q.pop_front();
        w_flat = want;
        g_flat = out_item;
        for (int k = 0; k < 8; k++) begin
          if (w_flat[(7-k)*16 +: 16] !== g_flat[(7-k)*16 +: 16]) begin
            $display("%0t out_%0d mismatch: expected %04h, actual %04h", $time, k,
                     w_flat[(7-k)*16 +: 16], g_flat[(7-k)*16 +: 16]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc >= LIMIT_CYCLES) begin
      $display("gf216_mds_round_linear_layer_core verification failed");
      $finish;
    end
  end

endmodule
